>>> src/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Types, constants and helper functions shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int GRID_SIZE   = 64;
  localparam int COORD_W     = 6;
  localparam int VALUE_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(GRID_SIZE - 1);

  typedef struct packed {
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
    logic [VALUE_W-1:0] paint_value;
  } cmd_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] plot_row;
    logic [COORD_W-1:0] plot_col;
    logic [VALUE_W-1:0] plot_value;
    logic               last_cell;
  } plot_item_t;

  // Classified line command, as queued between front and back.
  typedef struct packed {
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] end_row;
    logic [COORD_W-1:0] end_col;
    logic [COORD_W-1:0] len;        // major axis length (d)
    logic [COORD_W:0]   row_step;   // signed row delta
    logic [COORD_W:0]   col_step;   // signed col delta
    logic [COORD_W-1:0] rem_init;   // (d - s) / 2
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] quo;
    logic [COORD_W-1:0] rem;
  } axis_t;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    logic [COORD_W:0] wide;
    wide = {1'b0, c};
    if (wide > (COORD_W+1)'(GRID_SIZE - 1)) return COORD_MAX;
    return c;
  endfunction

  // One DDA step on an axis kept as quotient and remainder of acc / d.
  // |step| <= d and rem < d, so one correction keeps rem in range.
  function automatic axis_t axis_step(input axis_t cur,
                                      input logic [COORD_W:0] step,
                                      input logic [COORD_W-1:0] len);
    logic signed [COORD_W+1:0] sum;
    logic signed [COORD_W+1:0] dl;
    axis_t nxt;
    sum = $signed({2'b00, cur.rem}) + $signed({step[COORD_W], step});
    dl  = $signed({2'b00, len});
    if (sum >= dl) begin
      nxt.rem = COORD_W'(sum - dl);
      nxt.quo = cur.quo + COORD_W'(1);
    end else if (sum < 0) begin
      nxt.rem = COORD_W'(sum + dl);
      nxt.quo = cur.quo - COORD_W'(1);
    end else begin
      nxt.rem = COORD_W'(sum);
      nxt.quo = cur.quo;
    end
    return nxt;
  endfunction

endpackage

>>> src/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Accepts line commands, clamps the points and works out deltas, major axis
// length and the starting remainder for the back end.
// ----------------------------------------------------------------------------
module lr_front (
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  lr_pkg::cmd_item_t  cmd,
  output logic               push,
  input  logic               full,
  output lr_pkg::cmd_t       classified
);

  logic [lr_pkg::COORD_W-1:0] r0, c0, r1, c1;
  logic [lr_pkg::COORD_W:0]   dr, dc;
  logic [lr_pkg::COORD_W-1:0] abs_r, abs_c, len;
  logic                       same;
  logic [lr_pkg::COORD_W:0]   half_in;

  always_comb begin
    r0 = lr_pkg::clamp_coord(cmd.start_row);
    c0 = lr_pkg::clamp_coord(cmd.start_col);
    r1 = lr_pkg::clamp_coord(cmd.end_row);
    c1 = lr_pkg::clamp_coord(cmd.end_col);
    dr = {1'b0, r1} - {1'b0, r0};
    dc = {1'b0, c1} - {1'b0, c0};
    abs_r = dr[lr_pkg::COORD_W] ? lr_pkg::COORD_W'(-dr) : dr[lr_pkg::COORD_W-1:0];
    abs_c = dc[lr_pkg::COORD_W] ? lr_pkg::COORD_W'(-dc) : dc[lr_pkg::COORD_W-1:0];
    len   = (abs_r > abs_c) ? abs_r : abs_c;
    // both deltas nonzero with the same sign
    same  = (abs_r != '0) && (abs_c != '0) && (dr[lr_pkg::COORD_W] == dc[lr_pkg::COORD_W]);
    // len = 0 gives a junk remainder, but then no step cell is made
    half_in = {1'b0, len} - (lr_pkg::COORD_W+1)'(!same);

    classified.start_row = r0;
    classified.start_col = c0;
    classified.end_row   = r1;
    classified.end_col   = c1;
    classified.len       = len;
    classified.row_step  = dr;
    classified.col_step  = dc;
    classified.rem_init  = half_in[lr_pkg::COORD_W:1];
    classified.value     = cmd.paint_value;
  end

  assign cmd_stall = full;
  assign push      = cmd_valid && !full;

endmodule

>>> src/lr_queue.sv
// ----------------------------------------------------------------------------
// lr_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lr_pkg::cmd_t  wr_cmd,
  output logic          full,
  input  logic          pop,
  output logic          rd_valid,
  output lr_pkg::cmd_t  rd_cmd
);

  localparam int PTR_W = $clog2(lr_pkg::QUEUE_DEPTH);

  lr_pkg::cmd_t     entries [lr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W+1)'(lr_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + (PTR_W+1)'(1);
      else if (pop && !push) count <= count - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

endmodule

>>> src/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Steps one queued line at a time, one cell per cycle while the output is not
// stalled, into the output register; the end point closes each line.
// ----------------------------------------------------------------------------
module lr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_valid,
  input  lr_pkg::cmd_t       rd_cmd,
  output logic               pop,
  output logic               plot_valid,
  input  logic               plot_stall,
  output lr_pkg::plot_item_t plot
);

  logic                       busy;
  lr_pkg::cmd_t               cur;
  lr_pkg::axis_t              row_ax, col_ax, row_next, col_next;
  logic [lr_pkg::COORD_W-1:0] remaining;
  logic                       adv, emit, fin, load;

  assign adv  = !plot_valid || !plot_stall;
  assign emit = busy && adv;
  assign fin  = emit && (remaining == '0);
  assign load = rd_valid && (!busy || fin);
  assign pop  = load;

  always_comb begin
    row_next = lr_pkg::axis_step(row_ax, cur.row_step, cur.len);
    col_next = lr_pkg::axis_step(col_ax, cur.col_step, cur.len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      plot_valid <= 1'b0;
    end else begin
      if (adv) plot_valid <= busy;
      if (load)     busy <= 1'b1;
      else if (fin) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      plot.plot_value <= cur.value;
      if (remaining == '0) begin
        plot.plot_row  <= cur.end_row;
        plot.plot_col  <= cur.end_col;
        plot.last_cell <= 1'b1;
      end else begin
        plot.plot_row  <= row_ax.quo;
        plot.plot_col  <= col_ax.quo;
        plot.last_cell <= 1'b0;
      end
    end
    if (load) begin
      cur        <= rd_cmd;
      row_ax.quo <= rd_cmd.start_row;
      row_ax.rem <= rd_cmd.rem_init;
      col_ax.quo <= rd_cmd.start_col;
      col_ax.rem <= rd_cmd.rem_init;
      remaining  <= rd_cmd.len;
    end else if (emit && (remaining != '0)) begin
      row_ax    <= row_next;
      col_ax    <= col_next;
      remaining <= remaining - lr_pkg::COORD_W'(1);
    end
  end

endmodule

>>> src/line_rasterizer_top.sv
// The first cell of a line passes through a queue entry and the back end's
// axis registers before it reaches the output register.
// A line of major length d gives d+1 cells (1 to 64), one per cycle while the
// output does not stall, from the single stepping sequencer.
// Reset (rst, synchronous) empties the command queue and the output register.
// ----------------------------------------------------------------------------
// line_rasterizer_top
// DDA line rasterizer: classifying front end, two-entry command queue and a
// stepping back end that emits one grid cell per cycle while not stalled.
// ----------------------------------------------------------------------------
module line_rasterizer_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  lr_pkg::cmd_item_t  cmd,
  output logic               plot_valid,
  input  logic               plot_stall,
  output lr_pkg::plot_item_t plot
);

  lr_pkg::cmd_t classified, rd_cmd;
  logic         push, full, pop, rd_valid;

  lr_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .push       (push),
    .full       (full),
    .classified (classified)
  );

  lr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_cmd   (classified),
    .full     (full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_cmd   (rd_cmd)
  );

  lr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_valid   (rd_valid),
    .rd_cmd     (rd_cmd),
    .pop        (pop),
    .plot_valid (plot_valid),
    .plot_stall (plot_stall),
    .plot       (plot)
  );

endmodule

>>> dv/tb_line_rasterizer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_rasterizer_top
// Self-checking bench for the line rasterizer. Line commands (directed corner
// cases, then random lines) go in under random gaps; the emitted cells are
// compared in order against a DDA predictor while the output side stalls at
// random.
// ----------------------------------------------------------------------------
module tb_line_rasterizer_top;

  localparam int RANDOM_LINES = 260;
  localparam int STUCK_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  class cell_scoreboard;
    lr_pkg::plot_item_t cells_due[$];
    int                 errors = 0;

    function int grid_clip(int v);
      return (v > lr_pkg::GRID_SIZE - 1) ? lr_pkg::GRID_SIZE - 1 : v;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Rasterize one accepted line and queue the cells it must produce.
    function void note_line(lr_pkg::cmd_item_t c);
      int r0, c0, r1, c1, dr, dc, d, s, acc_r, acc_c, n;
      lr_pkg::plot_item_t dot;
      r0 = grid_clip(int'(c.start_row));
      c0 = grid_clip(int'(c.start_col));
      r1 = grid_clip(int'(c.end_row));
      c1 = grid_clip(int'(c.end_col));
      dr = r1 - r0;
      dc = c1 - c0;
      d  = (dr < 0 ? -dr : dr) > (dc < 0 ? -dc : dc) ? (dr < 0 ? -dr : dr)
                                                   : (dc < 0 ? -dc : dc);
      s  = ((dr > 0 && dc > 0) || (dr < 0 && dc < 0)) ? 0 : 1;
      n  = 0;
      dot.plot_value = c.paint_value;
      dot.last_cell  = 1'b0;
      if (d > 0) begin
        acc_r = r0 * d + (d - s) / 2;
        acc_c = c0 * d + (d - s) / 2;
        while (n < d && n < lr_pkg::GRID_SIZE - 1) begin
          dot.plot_row = lr_pkg::COORD_W'(acc_r / d);
          dot.plot_col = lr_pkg::COORD_W'(acc_c / d);
          cells_due.push_back(dot);
          acc_r += dr;
          acc_c += dc;
          n++;
        end
      end
      dot.plot_row  = lr_pkg::COORD_W'(r1);
      dot.plot_col  = lr_pkg::COORD_W'(c1);
      dot.last_cell = 1'b1;
      cells_due.push_back(dot);
    endfunction

    function void check_cell(lr_pkg::plot_item_t got);
      lr_pkg::plot_item_t want;
      if (cells_due.size() == 0) begin
        flag($sformatf("unexpected cell row=%0d col=%0d value=%h last=%b",
                       got.plot_row, got.plot_col, got.plot_value, got.last_cell));
        return;
      end
      want = cells_due.pop_front();
      if (got.plot_row !== want.plot_row || got.plot_col !== want.plot_col ||
          got.plot_value !== want.plot_value || got.last_cell !== want.last_cell)
        flag($sformatf({"cell mismatch: exp row=%0d col=%0d value=%h last=%b, ",
                        "got row=%0d col=%0d value=%h last=%b"},
                       want.plot_row, want.plot_col, want.plot_value, want.last_cell,
                       got.plot_row, got.plot_col, got.plot_value, got.last_cell));
    endfunction
  endclass

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               cmd_valid  = 1'b0;
  logic               cmd_stall;
  lr_pkg::cmd_item_t  cmd        = '0;
  logic               plot_valid;
  logic               plot_stall = 1'b0;
  lr_pkg::plot_item_t plot;

  cell_scoreboard sb = new();
  bit  calm_cmd  = 1'b0;
  bit  calm_plot = 1'b0;
  int  stuck     = 0;

  line_rasterizer_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .plot_valid (plot_valid),
    .plot_stall (plot_stall),
    .plot       (plot)
  );

  always #10 clk = ~clk;

  // Monitor: both handshakes are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.note_line(cmd);
      if (plot_valid && !plot_stall) sb.check_cell(plot);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (plot_valid && !plot_stall)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck == STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_line(input lr_pkg::cmd_item_t item);
    int gap;
    gap = calm_cmd ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid <= 1'b1;
    cmd       <= item;
    do @(posedge clk); while (cmd_stall !== 1'b0);
  endtask

  // Output side: a random stall before each cell, with calm stretches.
  initial begin
    int hold;
    wait (!rst);
    forever begin
      hold = calm_plot ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        @(negedge clk);
        plot_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      plot_stall <= 1'b0;
      do @(posedge clk); while (plot_valid !== 1'b1);
      if ($urandom_range(0, 59) == 0) calm_plot = ~calm_plot;
    end
  end

  initial begin
    lr_pkg::cmd_item_t directed[$];
    lr_pkg::cmd_item_t item;
    int r, c, er, ec;
    directed = '{
      '{6'd0,  6'd0,  6'd63, 6'd63, 32'h0000_0000},  // full diagonal down
      '{6'd63, 6'd63, 6'd0,  6'd0,  32'hFFFF_FFFF},  // full diagonal up
      '{6'd0,  6'd63, 6'd63, 6'd0,  32'hAAAA_AAAA},  // anti-diagonal
      '{6'd63, 6'd0,  6'd0,  6'd63, 32'h5555_5555},
      '{6'd0,  6'd0,  6'd0,  6'd0,  32'h1234_5678},  // single point
      '{6'd63, 6'd63, 6'd63, 6'd63, 32'h8765_4321},
      '{6'd5,  6'd0,  6'd5,  6'd63, 32'hDEAD_BEEF},  // horizontal
      '{6'd5,  6'd63, 6'd5,  6'd0,  32'h0F0F_0F0F},
      '{6'd0,  6'd7,  6'd63, 6'd7,  32'hF0F0_F0F0},  // vertical
      '{6'd63, 6'd7,  6'd0,  6'd7,  32'h0000_0001},
      '{6'd10, 6'd10, 6'd11, 6'd10, 32'h8000_0000},  // length one
      '{6'd10, 6'd10, 6'd10, 6'd9,  32'h7FFF_FFFF},
      '{6'd20, 6'd20, 6'd21, 6'd21, 32'hCAFE_F00D},
      '{6'd0,  6'd0,  6'd63, 6'd1,  32'h0102_0304},  // steep, same sign
      '{6'd0,  6'd1,  6'd63, 6'd0,  32'hA5A5_5A5A},  // steep, opposite sign
      '{6'd1,  6'd0,  6'd0,  6'd63, 32'h5A5A_A5A5},  // shallow, opposite sign
      '{6'd0,  6'd0,  6'd1,  6'd63, 32'hFF00_FF00},
      '{6'd30, 6'd30, 6'd33, 6'd40, 32'h00FF_00FF},
      '{6'd40, 6'd33, 6'd30, 6'd30, 32'hC3C3_3C3C},
      '{6'd12, 6'd50, 6'd40, 6'd3,  32'h3C3C_C3C3},
      '{6'd63, 6'd62, 6'd0,  6'd63, 32'h1111_EEEE}
    };
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_line(directed[i]);

    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i % 40 == 0) calm_cmd = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
      case ($urandom_range(0, 7))
        0, 1, 2: begin  // short lines keep the run time down
          er = r + $urandom_range(0, 8) - 4;
          ec = c + $urandom_range(0, 8) - 4;
        end
        3: begin
          if ($urandom_range(0, 1)) begin
            er = r;
            ec = $urandom_range(0, 63);
          end else begin
            er = $urandom_range(0, 63);
            ec = c;
          end
        end
        4: begin
          er = r;
          ec = c;
        end
        default: begin
          er = $urandom_range(0, 63);
          ec = $urandom_range(0, 63);
        end
      endcase
      er = er < 0 ? 0 : (er > 63 ? 63 : er);
      ec = ec < 0 ? 0 : (ec > 63 ? 63 : ec);
      item.start_row   = lr_pkg::COORD_W'(r);
      item.start_col   = lr_pkg::COORD_W'(c);
      item.end_row     = lr_pkg::COORD_W'(er);
      item.end_col     = lr_pkg::COORD_W'(ec);
      item.paint_value = $urandom();
      send_line(item);
    end

    @(negedge clk);
    cmd_valid <= 1'b0;
    while (sb.cells_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.cells_due.size() != 0) sb.flag("cells still outstanding at end of run");
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/lr_pkg.sv
src/lr_front.sv
src/lr_queue.sv
src/lr_back.sv
src/line_rasterizer_top.sv
dv/tb_line_rasterizer_top.sv
